[rtl/imt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imt_pkg
// Shared constants, types and the slot hash of the identity map intern table.
// ----------------------------------------------------------------------------
package imt_pkg;

    localparam int SLOTS    = 1024;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = SLOT_W + 1;
    localparam int KEY_W    = 64;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 3;
    localparam int LOAD_NUM = 7;
    localparam int LOAD_DEN = 10;
    // smallest entry count at which count * 10 >= SLOTS * 7
    localparam int FULL_LIMIT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INTERN = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } t_slot;

    typedef struct packed {
        logic clr;
        logic load;
        logic zero;
        logic advance;
        logic resolve;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_zero;
        logic hit;
        logic empty;
        logic out_free;
    } t_dp_sts;

    // xor fold of the key into a slot number, folded once more into range
    function automatic logic [SLOT_W-1:0] home_slot(input logic [KEY_W-1:0] key);
        logic [SLOT_W-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % SLOT_W] = h[i % SLOT_W] ^ key[i];
        end
        if ({1'b0, h} >= (SLOT_W + 1)'(SLOTS)) begin
            h = h - SLOT_W'(SLOTS);
        end
        return h;
    endfunction

endpackage

[rtl/imt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imt_in_if / imt_out_if
// Valid-ready channels for requests and results of the intern table.
// ----------------------------------------------------------------------------
interface imt_in_if
    import imt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [KEY_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface imt_out_if
    import imt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    entry_index;

    modport source (output valid, output status, output entry_index, input ready);
    modport sink   (input valid, input status, input entry_index, output ready);
endinterface

[rtl/imt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imt_dp
// Datapath: slot memory, probe pointer, entry counter and result register.
// ----------------------------------------------------------------------------
module imt_dp
    import imt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_operation,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_entry_index
);

    t_slot               r_mem [SLOTS];
    t_slot               r_rd;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_clr_addr;
    logic [KEY_W-1:0]    r_key;
    logic                r_op;
    logic [CNT_W-1:0]    r_count;
    logic [STATUS_W-1:0] r_res_status;
    logic [IDX_W-1:0]    r_res_idx;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [IDX_W-1:0]    r_out_idx;

    logic                mem_we;
    logic [SLOT_W-1:0]   mem_wa;
    t_slot               mem_wd;
    logic                full;
    logic [IDX_W-1:0]    new_idx;
    logic [STATUS_W-1:0] n_res_status;
    logic [IDX_W-1:0]    n_res_idx;
    logic                do_insert;

    assign full    = (r_count >= CNT_W'(FULL_LIMIT));
    assign new_idx = IDX_W'(r_count);

    always_comb begin
        do_insert    = 1'b0;
        n_res_status = ST_FOUND;
        n_res_idx    = '0;
        priority if (o_sts.hit) begin
            n_res_idx = r_rd.idx;
        end else if (r_op == OP_LOOKUP) begin
            n_res_status = ST_MISS;
        end else if (full) begin
            n_res_status = ST_FULL;
        end else begin
            n_res_status = ST_INSERTED;
            n_res_idx    = new_idx;
            do_insert    = 1'b1;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_slot;
        mem_wd = '{key: r_key, idx: new_idx};
        if (i_cmd.clr) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else if (i_cmd.resolve && do_insert) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.resolve && do_insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_key;
            r_op   <= i_operation;
            r_slot <= home_slot(i_key);
        end else if (i_cmd.advance) begin
            r_slot <= (r_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_slot + 1'b1;
        end
        if (i_cmd.zero) begin
            r_res_status <= ST_ZERO;
            r_res_idx    <= '0;
        end else if (i_cmd.resolve) begin
            r_res_status <= n_res_status;
            r_res_idx    <= n_res_idx;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_idx    <= r_res_idx;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == SLOT_W'(SLOTS - 1));
    assign o_sts.in_zero  = (i_key == '0);
    assign o_sts.hit      = (r_rd.key == r_key);
    assign o_sts.empty    = (r_rd.key == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;

endmodule

[rtl/imt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imt_ctrl
// Controller: clearing sweep, probe sequencing and result hand-off.
// ----------------------------------------------------------------------------
module imt_ctrl
    import imt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.in_zero) begin
                        o_cmd.zero = 1'b1;
                        n_state    = S_RESP;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit || i_sts.empty) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_RESP;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/identity_map_intern_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// identity_map_intern_table_core
// Open-addressed intern table mapping nonzero 64-bit keys to dense indices.
// ----------------------------------------------------------------------------
// After reset the table runs a clearing sweep over all SLOTS slots with
// input ready low. A request then probes slots in turn: each probe is
// one registered memory read followed by a compare, and that pair sets
// the pace. A zero key skips the probes and goes straight to the result
// register. A request is taken only when the previous result has been
// moved to the output register.
module identity_map_intern_table_core
    import imt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    imt_in_if.sink    i_in,
    imt_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    imt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    imt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_operation   (i_in.operation),
        .i_key         (i_in.key),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_status      (o_out.status),
        .o_entry_index (o_out.entry_index)
    );

    // input ready is low right after reset, at the start of the clearing sweep
    a_no_accept_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in.ready)
        else $error("request taken during clearing sweep");

    // only a found or inserted result carries an index
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_FOUND && o_out.status != ST_INSERTED)
        |-> (o_out.entry_index == '0))
        else $error("index set on a result without an entry");

    // a zero key request yields a zero key result once the output is free
    a_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.key == '0 && !o_out.valid)
        |=> ##1 (o_out.valid && o_out.status == ST_ZERO))
        else $error("zero key not reported");

endmodule
